### rtl/servo_write_frame_builder_top_macros.svh
// Assertion macros for the servo write frame builder.
`ifndef SERVO_WRITE_FRAME_BUILDER_TOP_MACROS_SVH
`define SERVO_WRITE_FRAME_BUILDER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// ante implies cons on the same edge
`define SWFB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// ante implies cons on the next edge
`define SWFB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWFB_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SWFB_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/swfb_pkg.sv
// Shared types and constants for the servo write frame builder.
`default_nettype none
package swfb_pkg;

  localparam logic [7:0] BYTE_HDR      = 8'hFF;
  localparam logic [7:0] LEN_WRITE     = 8'h09;
  localparam logic [7:0] INST_REG_WR   = 8'h04;
  localparam logic [7:0] LEN_ACTION    = 8'h02;
  localparam logic [7:0] INST_ACTION   = 8'h05;

  localparam logic [7:0] START_REG_RST = 8'h2A;
  localparam logic [7:0] BCAST_ID_RST  = 8'hFE;

  localparam logic [1:0] REG_START_REGISTER = 2'd0;
  localparam logic [1:0] REG_BROADCAST_ID   = 2'd1;

  // one classified command, ready to serialize
  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] target_position;
    logic [15:0] move_time;
    logic [15:0] move_speed;
    logic        last_command;
    logic [7:0]  start_register;
    logic [7:0]  write_csum;
    logic [7:0]  broadcast_id;
    logic [7:0]  action_csum;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage
`default_nettype wire

### rtl/swfb_front.sv
// Front stage: takes commands, computes both checksums, hands off to the queue.
`default_nettype none
module swfb_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [7:0]          servo_id,
  input  wire logic [15:0]         target_position,
  input  wire logic [15:0]         move_time,
  input  wire logic [15:0]         move_speed,
  input  wire logic                last_command,
  input  wire logic [7:0]          start_register,
  input  wire logic [7:0]          broadcast_id,
  input  wire swfb_pkg::qstat_t    qstat,
  output logic                     q_push,
  output swfb_pkg::cmd_t           q_data,
  output logic                     front_valid
);

  logic [7:0] write_csum;
  logic [7:0] action_csum;
  logic [7:0] wsum;
  logic [7:0] asum;
  logic       take;

  always_comb begin
    wsum = servo_id + swfb_pkg::LEN_WRITE + swfb_pkg::INST_REG_WR + start_register
         + target_position[7:0] + target_position[15:8]
         + move_time[7:0] + move_time[15:8]
         + move_speed[7:0] + move_speed[15:8];
    asum = broadcast_id + swfb_pkg::LEN_ACTION + swfb_pkg::INST_ACTION;
    write_csum  = ~wsum;
    action_csum = ~asum;
  end

  assign q_push = front_valid && !qstat.full;
  assign full   = front_valid && qstat.full;
  assign take   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (take) begin
      front_valid <= 1'b1;
    end else if (q_push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_data.servo_id        <= servo_id;
      q_data.target_position <= target_position;
      q_data.move_time       <= move_time;
      q_data.move_speed      <= move_speed;
      q_data.last_command    <= last_command;
      q_data.start_register  <= start_register;
      q_data.write_csum      <= write_csum;
      q_data.broadcast_id    <= broadcast_id;
      q_data.action_csum     <= action_csum;
    end
  end

endmodule
`default_nettype wire

### rtl/swfb_queue.sv
// Short command queue between the front stage and the serializer.
`default_nettype none
module swfb_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire swfb_pkg::cmd_t   wdata,
  input  wire logic             pop,
  output swfb_pkg::cmd_t        rdata,
  output swfb_pkg::qstat_t      qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  swfb_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CNT_FULL);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign rdata       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/swfb_back.sv
// Serializer: walks the queue head byte by byte into the output register.
`default_nettype none
module swfb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire swfb_pkg::cmd_t   cmd,
  input  wire swfb_pkg::qstat_t qstat,
  output logic                  q_pop,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            tx_byte,
  output logic                  frame_end,
  output logic                  run_last
);

  localparam logic [4:0] IDX_HDR0   = 5'd0;
  localparam logic [4:0] IDX_HDR1   = 5'd1;
  localparam logic [4:0] IDX_ID     = 5'd2;
  localparam logic [4:0] IDX_LEN    = 5'd3;
  localparam logic [4:0] IDX_INST   = 5'd4;
  localparam logic [4:0] IDX_REG    = 5'd5;
  localparam logic [4:0] IDX_POS_L  = 5'd6;
  localparam logic [4:0] IDX_POS_H  = 5'd7;
  localparam logic [4:0] IDX_TIM_L  = 5'd8;
  localparam logic [4:0] IDX_TIM_H  = 5'd9;
  localparam logic [4:0] IDX_SPD_L  = 5'd10;
  localparam logic [4:0] IDX_SPD_H  = 5'd11;
  localparam logic [4:0] IDX_WCSUM  = 5'd12;
  localparam logic [4:0] IDX_AHDR0  = 5'd13;
  localparam logic [4:0] IDX_AHDR1  = 5'd14;
  localparam logic [4:0] IDX_AID    = 5'd15;
  localparam logic [4:0] IDX_ALEN   = 5'd16;
  localparam logic [4:0] IDX_AINST  = 5'd17;
  localparam logic [4:0] IDX_ACSUM  = 5'd18;

  logic [4:0] idx;
  logic [7:0] byte_sel;
  logic       end_sel;
  logic       last_sel;
  logic       out_valid;
  logic       out_ready;
  logic       load;

  always_comb begin
    unique case (idx)
      IDX_HDR0, IDX_HDR1,
      IDX_AHDR0, IDX_AHDR1: byte_sel = swfb_pkg::BYTE_HDR;
      IDX_ID:               byte_sel = cmd.servo_id;
      IDX_LEN:              byte_sel = swfb_pkg::LEN_WRITE;
      IDX_INST:             byte_sel = swfb_pkg::INST_REG_WR;
      IDX_REG:              byte_sel = cmd.start_register;
      IDX_POS_L:            byte_sel = cmd.target_position[7:0];
      IDX_POS_H:            byte_sel = cmd.target_position[15:8];
      IDX_TIM_L:            byte_sel = cmd.move_time[7:0];
      IDX_TIM_H:            byte_sel = cmd.move_time[15:8];
      IDX_SPD_L:            byte_sel = cmd.move_speed[7:0];
      IDX_SPD_H:            byte_sel = cmd.move_speed[15:8];
      IDX_WCSUM:            byte_sel = cmd.write_csum;
      IDX_AID:              byte_sel = cmd.broadcast_id;
      IDX_ALEN:             byte_sel = swfb_pkg::LEN_ACTION;
      IDX_AINST:            byte_sel = swfb_pkg::INST_ACTION;
      IDX_ACSUM:            byte_sel = cmd.action_csum;
      default:              byte_sel = swfb_pkg::BYTE_HDR;
    endcase
  end

  assign end_sel   = (idx == IDX_WCSUM) || (idx == IDX_ACSUM);
  assign last_sel  = ((idx == IDX_WCSUM) && !cmd.last_command) || (idx == IDX_ACSUM);
  assign empty     = !out_valid;
  assign out_ready = !out_valid || pop;
  assign load      = out_ready && !qstat.empty;
  assign q_pop     = load && last_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= IDX_HDR0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last_sel ? IDX_HDR0 : idx + 5'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte   <= byte_sel;
      frame_end <= end_sel;
      run_last  <= last_sel;
    end
  end

endmodule
`default_nettype wire

### rtl/servo_write_frame_builder_top.sv
// Top level of the servo write frame builder: config registers and stage wiring.
// Each pushed command becomes a 13-byte deferred register-write frame
// (FF FF id 09 04 reg posL posH timL timH spdL spdH csum) and, when
// last_command is set, a 6-byte action frame (FF FF bcast 02 05 csum) follows.
// Result beats are single bytes; frame_end marks each checksum byte and run_last
// the final byte of a command. The serializer emits one byte per clock while pop
// is held and a command is queued, so a command occupies 13 bytes of the output,
// or 19 with the action frame; that byte serializer is what sets throughput.
// Checksums are formed in the front stage, and a QUEUE_DEPTH deep queue lets new
// commands be pushed while earlier frames are still going out. A pushed command
// passes the front register, the queue and the output register on its way out.
// start_register and broadcast_id are sampled when a command is pushed.
`default_nettype none
`include "servo_write_frame_builder_top_macros.svh"
module servo_write_frame_builder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command side
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  servo_id,
  input  wire logic [15:0] target_position,
  input  wire logic [15:0] move_time,
  input  wire logic [15:0] move_speed,
  input  wire logic        last_command,
  // byte side
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       tx_byte,
  output logic             frame_end,
  output logic             run_last,
  // config write port
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic              [7:0] start_register;
  logic              [7:0] broadcast_id;
  logic                    q_push;
  logic                    q_pop;
  logic                    front_valid;
  swfb_pkg::cmd_t          q_wdata;
  swfb_pkg::cmd_t          q_rdata;
  swfb_pkg::qstat_t        qstat;

  // config registers; unknown indexes fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      start_register <= swfb_pkg::START_REG_RST;
      broadcast_id   <= swfb_pkg::BCAST_ID_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        swfb_pkg::REG_START_REGISTER: start_register <= cfg_data;
        swfb_pkg::REG_BROADCAST_ID:   broadcast_id   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: capture command, build checksums
  swfb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .servo_id        (servo_id),
    .target_position (target_position),
    .move_time       (move_time),
    .move_speed      (move_speed),
    .last_command    (last_command),
    .start_register  (start_register),
    .broadcast_id    (broadcast_id),
    .qstat           (qstat),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .front_valid     (front_valid)
  );

  // decoupling queue
  swfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  // back: byte serializer with output register
  swfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_rdata),
    .qstat     (qstat),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .tx_byte   (tx_byte),
    .frame_end (frame_end),
    .run_last  (run_last)
  );

  // the last byte of a command always closes a frame
  `SWFB_ASSERT_IMP(a_last_is_end, clk, rst, !empty && run_last, frame_end, "run_last w/o end")
  // serializer retires a command only when one is queued
  `SWFB_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, !qstat.empty, "queue popped while empty")
  // backpressure only when the front stage holds a command
  `SWFB_ASSERT_IMP(a_full_front, clk, rst, full, front_valid && qstat.full, "full w/o command")
  // a retired command frees a queue slot on the next edge
  `SWFB_ASSERT_NXT(a_pop_frees, clk, rst, q_pop && !q_push, !qstat.full, "still full after pop")

endmodule
`default_nettype wire

### verif/tb_servo_write_frame_builder_top.sv
`timescale 1ns / 100ps
// Testbench for servo_write_frame_builder_top: directed and random commands, byte-level checks.
module tb_servo_write_frame_builder_top;

  // indexes with no register behind them; writes there must be dropped
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  // covers the push-to-first-byte path when idle, with margin
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 5;
  localparam int CMDS_PER_PHASE = 50;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] pos;
    logic [15:0] tim;
    logic [15:0] spd;
    logic        last;
  } servo_cmd_t;

  // one output beat: a single bus byte plus its markers
  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       run_last;
  } tx_beat_t;

  // Frame predictor plus expected-byte queue. Holds its own copy of the
  // two config registers, updated on every register write the bench does.
  class frame_scoreboard;
    logic [7:0] start_reg = swfb_pkg::START_REG_RST;
    logic [7:0] bcast_id  = swfb_pkg::BCAST_ID_RST;
    tx_beat_t   pending_bytes[$];
    int errors = 0;
    int bytes_checked = 0;
    int cmds_seen = 0;
    int action_frames = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        swfb_pkg::REG_START_REGISTER: start_reg = val;
        swfb_pkg::REG_BROADCAST_ID:   bcast_id = val;
        default: ;  // unmapped index, ignored by the block
      endcase
    endfunction

    function void add_byte(logic [7:0] data, logic fe, logic rl);
      tx_beat_t b;
      b.data = data;
      b.frame_end = fe;
      b.run_last = rl;
      pending_bytes.push_back(b);
    endfunction

    // accepted command -> 13 write-frame bytes, plus 6 action bytes if last
    function void note_command(servo_cmd_t c);
      logic [7:0] body [10];
      logic [7:0] sum;
      body = '{c.id, swfb_pkg::LEN_WRITE, swfb_pkg::INST_REG_WR, start_reg,
               c.pos[7:0], c.pos[15:8], c.tim[7:0], c.tim[15:8],
               c.spd[7:0], c.spd[15:8]};
      cmds_seen++;
      add_byte(swfb_pkg::BYTE_HDR, 1'b0, 1'b0);
      add_byte(swfb_pkg::BYTE_HDR, 1'b0, 1'b0);
      sum = '0;
      foreach (body[i]) begin
        add_byte(body[i], 1'b0, 1'b0);
        sum = sum + body[i];  // wraps mod 256
      end
      add_byte(~sum, 1'b1, !c.last);
      if (c.last) begin
        action_frames++;
        add_byte(swfb_pkg::BYTE_HDR, 1'b0, 1'b0);
        add_byte(swfb_pkg::BYTE_HDR, 1'b0, 1'b0);
        add_byte(bcast_id, 1'b0, 1'b0);
        add_byte(swfb_pkg::LEN_ACTION, 1'b0, 1'b0);
        add_byte(swfb_pkg::INST_ACTION, 1'b0, 1'b0);
        sum = bcast_id + swfb_pkg::LEN_ACTION + swfb_pkg::INST_ACTION;
        add_byte(~sum, 1'b1, 1'b1);
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ns: MISMATCH %s", $time, msg);
    endfunction

    function void check_byte(logic [7:0] data, logic fe, logic rl);
      tx_beat_t want;
      if (pending_bytes.size() == 0) begin
        flag($sformatf("unexpected byte: expected none, got %02h fe=%b rl=%b",
                       data, fe, rl));
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (data !== want.data)
        flag($sformatf("byte %0d tx_byte: expected %02h, got %02h",
                       bytes_checked, want.data, data));
      if (fe !== want.frame_end)
        flag($sformatf("byte %0d frame_end: expected %b, got %b",
                       bytes_checked, want.frame_end, fe));
      if (rl !== want.run_last)
        flag($sformatf("byte %0d run_last: expected %b, got %b",
                       bytes_checked, want.run_last, rl));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  servo_id = '0;
  logic [15:0] target_position = '0;
  logic [15:0] move_time = '0;
  logic [15:0] move_speed = '0;
  logic        last_command = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  tx_byte;
  logic        frame_end;
  logic        run_last;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  frame_scoreboard sb = new();

  // idle rates in percent, per side; dropped to zero for one long stretch
  int send_idle_pct = 6;
  int pop_stall_pct = 6;
  int reg_settings = 1;  // reset values count as the first setting

  servo_write_frame_builder_top dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .servo_id        (servo_id),
    .target_position (target_position),
    .move_time       (move_time),
    .move_speed      (move_speed),
    .last_command    (last_command),
    .empty           (empty),
    .pop             (pop),
    .tx_byte         (tx_byte),
    .frame_end       (frame_end),
    .run_last        (run_last),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // Present one command from a falling edge until a rising edge sees it taken.
  // Returns at a falling edge with push still high, so the next command can
  // follow back to back; the caller lowers push when the burst is over.
  task automatic send_cmd(servo_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    servo_id <= c.id;
    target_position <= c.pos;
    move_time <= c.tim;
    move_speed <= c.spd;
    last_command <= c.last;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_command(c);
    @(negedge clk);
  endtask

  // Block is idle once every expected byte has gone out and the pipe has
  // had time to show any stray extra beat.
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one config write beat; leaves cfg_write high for the caller to drop
  task automatic cfg_beat(logic [1:0] idx, logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Write both registers while idle; optionally poke the unmapped indexes
  // afterwards, which must leave both registers untouched.
  task automatic program_regs(logic [7:0] start_v, logic [7:0] bcast_v, bit poke_spare);
    wait_drained();
    cfg_beat(swfb_pkg::REG_START_REGISTER, start_v);
    cfg_beat(swfb_pkg::REG_BROADCAST_ID, bcast_v);
    if (poke_spare) begin
      cfg_beat(REG_SPARE_A, 8'($urandom));
      cfg_beat(REG_SPARE_B, 8'($urandom));
    end
    cfg_write <= 1'b0;
    reg_settings++;
  endtask

  // Mostly uniform fields, with an occasional all-zero or all-one field so
  // checksum wrap and boundary bytes keep showing up in the random part.
  function automatic servo_cmd_t rand_cmd();
    servo_cmd_t c;
    c.id = 8'($urandom);
    c.pos = 16'($urandom);
    c.tim = 16'($urandom);
    c.spd = 16'($urandom);
    c.last = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: c.id = $urandom_range(1) ? 8'h00 : 8'hFF;
      1: c.pos = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      2: c.tim = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      3: c.spd = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      default: ;
    endcase
    return c;
  endfunction

  // Byte sink: pop changes at falling edges, beats are taken at rising edges.
  initial begin : byte_sink
    forever begin
      @(posedge clk);
      if (!rst && pop && empty === 1'b0) sb.check_byte(tx_byte, frame_end, run_last);
      @(negedge clk);
      pop <= !rst && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset register values. All-zero and all-one fields flip
    // every input bit; the all-ones command wraps the checksum sum.
    send_cmd(servo_cmd_t'{8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    send_cmd(servo_cmd_t'{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
    send_cmd(servo_cmd_t'{8'h01, 16'h00FF, 16'hFF00, 16'h8001, 1'b0});
    send_cmd(servo_cmd_t'{8'h80, 16'h5555, 16'hAAAA, 16'h0100, 1'b1});
    send_cmd(servo_cmd_t'{8'h7F, 16'h8000, 16'h0001, 16'hFFFE, 1'b0});
    send_cmd(servo_cmd_t'{8'hFE, 16'h0800, 16'h03E8, 16'h0000, 1'b1});
    send_cmd(servo_cmd_t'{8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1});

    // Both registers at zero, then spare-index writes that must not land.
    program_regs(8'h00, 8'h00, 1'b1);
    send_cmd(servo_cmd_t'{8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1});
    send_cmd(servo_cmd_t'{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
    send_cmd(servo_cmd_t'{8'h3C, 16'h1234, 16'h5678, 16'h9ABC, 1'b1});
    send_cmd(servo_cmd_t'{8'hC3, 16'hFEDC, 16'hBA98, 16'h7654, 1'b0});

    // Both registers at all ones; action checksum wraps here too.
    program_regs(8'hFF, 8'hFF, 1'b0);
    send_cmd(servo_cmd_t'{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
    send_cmd(servo_cmd_t'{8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    send_cmd(servo_cmd_t'{8'hAA, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1});
    send_cmd(servo_cmd_t'{8'h55, 16'h0000, 16'hFFFF, 16'h0000, 1'b1});

    // Random phases, each under its own register setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: program_regs(8'h00, 8'hFF, 1'b0);
        3: program_regs(8'($urandom), 8'($urandom), 1'b1);
        4: program_regs(swfb_pkg::START_REG_RST, swfb_pkg::BCAST_ID_RST, 1'b0);
        default: program_regs(8'($urandom), 8'($urandom), 1'b0);
      endcase
      if (p == 2) begin
        // long stretch with neither side idling: queue runs full
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end
      repeat (CMDS_PER_PHASE) send_cmd(rand_cmd());
      send_idle_pct = 6;
      pop_stall_pct = 6;
    end

    wait_drained();
    $display("Checked %0d commands (%0d with action frame) as %0d bytes",
             sb.cmds_seen, sb.action_frames, sb.bytes_checked);
    $display("over %0d register settings, %0d mismatches", reg_settings, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit: far above the slowest passing run
  initial begin : watchdog
    #(400_000);
    $display("timeout: %0d bytes still expected", sb.pending_bytes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
